### design/nons_pkg.sv
package nons_pkg;

	localparam int DEF_MAX_PARENTS  = 64;
	localparam int DEF_MAX_CHILDREN = 64;

	// generator constants
	localparam int          TW_N     = 624;
	localparam int          TW_M     = 397;
	localparam logic [31:0] TW_MULT  = 32'd1812433253;
	localparam logic [31:0] TW_MATA  = 32'h9908B0DF;
	localparam logic [31:0] FULL_ONE = 32'hFFFFFFFF;

	// input kinds
	localparam logic [2:0] K_PRIOR   = 3'd0;
	localparam logic [2:0] K_NOISE   = 3'd1;
	localparam logic [2:0] K_WEIGHT  = 3'd2;
	localparam logic [2:0] K_RESTART = 3'd3;
	localparam logic [2:0] K_SAMPLE  = 3'd4;

	// register indexes
	localparam logic [1:0] R_NPAR  = 2'd0;
	localparam logic [1:0] R_NCHI  = 2'd1;
	localparam logic [1:0] R_SEED  = 2'd2;

	// twister memory request
	typedef struct packed {
		logic        we;
		logic [9:0]  waddr;
		logic [31:0] wdata;
		logic [9:0]  raddr;
	} tw_req_t;

	function automatic logic [31:0] tw_temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & 32'h9D2C5680);
		y = y ^ ((y << 15) & 32'hEFC60000);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

### design/nons_tw_ram.sv
module nons_tw_ram
	import nons_pkg::*;
(
	input  logic        clk,
	input  tw_req_t     req,
	output logic [31:0] rdata
);

	logic [31:0] mem [TW_N];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

### design/noisy_or_network_sampler.sv
// channel  | signals                                           | dir
// in       | in_valid, in_stall, kind, parent_index,           | request in
//          | child_index, probability                          |
// out      | out_valid, out_stall, obs_bits                    | request out
// cfg      | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB
//
// Loads are written to their table as they are taken. A restart seeds the
// generator words one at a time through the multiply and add states. A sample
// reads its draws one at a time through the single memory read port (C noise,
// P prior and, per active parent, one per child whose weight is not exactly one),
// regenerating the memory when it is used up. After reset the generator is seeded
// from seed 0 and no request is taken meanwhile; config writes are always taken.
// A finished sample waits in the output register; loads go on behind it.
module noisy_or_network_sampler
	import nons_pkg::*;
#(
	parameter int MAX_PARENTS  = DEF_MAX_PARENTS,
	parameter int MAX_CHILDREN = DEF_MAX_CHILDREN
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [5:0]  parent_index,
	input  logic [5:0]  child_index,
	input  logic [31:0] probability,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] obs_bits,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PIW = (MAX_PARENTS  > 1) ? $clog2(MAX_PARENTS)  : 1;
	localparam int CIW = (MAX_CHILDREN > 1) ? $clog2(MAX_CHILDREN) : 1;
	localparam int NPW = $clog2(MAX_PARENTS + 1);
	localparam int NCW = $clog2(MAX_CHILDREN + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SEED0 = 4'd1;
	localparam logic [3:0] S_SMUL  = 4'd2;
	localparam logic [3:0] S_SADD  = 4'd3;
	localparam logic [3:0] S_ISSUE = 4'd4;
	localparam logic [3:0] S_EVAL  = 4'd5;
	localparam logic [3:0] S_RG0   = 4'd6;
	localparam logic [3:0] S_RGL   = 4'd7;
	localparam logic [3:0] S_RG1   = 4'd8;
	localparam logic [3:0] S_RG2   = 4'd9;
	localparam logic [3:0] S_RG3   = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	localparam logic [1:0] PH_NOISE  = 2'd0;
	localparam logic [1:0] PH_PRIOR  = 2'd1;
	localparam logic [1:0] PH_WEIGHT = 2'd2;

	localparam logic [9:0] N_W   = 10'(TW_N);
	localparam logic [9:0] M_W   = 10'(TW_M);

	// config registers
	logic [6:0]  npar_q, nchi_q;
	logic [31:0] seed_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npar_q <= 7'd1;
			nchi_q <= 7'd1;
			seed_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				R_NPAR:  npar_q <= pwdata[6:0];
				R_NCHI:  nchi_q <= pwdata[6:0];
				R_SEED:  seed_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			R_NPAR:  prdata = {25'd0, npar_q};
			R_NCHI:  prdata = {25'd0, nchi_q};
			R_SEED:  prdata = seed_q;
			default: prdata = '0;
		endcase
	end

	// effective counts, saturated at the table sizes
	logic [NPW-1:0] np_eff;
	logic [NCW-1:0] nc_eff;
	assign np_eff = (32'(npar_q) > MAX_PARENTS)  ? NPW'(MAX_PARENTS)  : NPW'(npar_q);
	assign nc_eff = (32'(nchi_q) > MAX_CHILDREN) ? NCW'(MAX_CHILDREN) : NCW'(nchi_q);

	// control state
	logic [3:0]     state_q;
	logic [1:0]     phase_q;
	logic [9:0]     pos_q, idx_q;
	logic [31:0]    prev_q, cur_q, nxt_q, mul_s1;
	logic [PIW-1:0] p_q;
	logic [CIW-1:0] c_q;
	logic [MAX_CHILDREN-1:0] bits_q;
	logic           out_valid_q;
	logic [63:0]    out_bits_q;

	logic in_acc;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// table loads
	logic [PIW-1:0] ld_p;
	logic [CIW-1:0] ld_c;
	logic           p_ok, c_ok;
	assign ld_p = PIW'(parent_index);
	assign ld_c = CIW'(child_index);
	assign p_ok = (32'(parent_index) < MAX_PARENTS);
	assign c_ok = (32'(child_index)  < MAX_CHILDREN);

	logic [31:0] prior_mem  [MAX_PARENTS];
	logic [31:0] noise_mem  [MAX_CHILDREN];
	logic [31:0] weight_mem [MAX_PARENTS * (2 ** CIW)];
	logic [31:0] prior_rd_q, noise_rd_q, weight_rd_q;

	always_ff @(posedge clk) begin
		if (in_acc && kind == K_PRIOR && p_ok) begin
			prior_mem[ld_p] <= probability;
		end
		if (in_acc && kind == K_NOISE && c_ok) begin
			noise_mem[ld_c] <= probability;
		end
		if (in_acc && kind == K_WEIGHT && p_ok && c_ok) begin
			weight_mem[{ld_p, ld_c}] <= probability;
		end
		prior_rd_q  <= prior_mem[p_q];
		noise_rd_q  <= noise_mem[c_q];
		weight_rd_q <= weight_mem[{p_q, c_q}];
	end

	// generator word memory
	tw_req_t     tw_req;
	logic [31:0] tw_rd;

	nons_tw_ram u_ram (
		.clk   (clk),
		.req   (tw_req),
		.rdata (tw_rd)
	);

	logic [9:0]  idx_p1, idx_pm;
	logic [31:0] seed_word, regen_y, regen_word;
	assign idx_p1     = (idx_q == N_W - 10'd1) ? 10'd0 : idx_q + 10'd1;
	assign idx_pm     = (idx_q + M_W >= N_W) ? idx_q + M_W - N_W : idx_q + M_W;
	assign seed_word  = mul_s1 + {22'd0, idx_q};
	assign regen_y    = {cur_q[31], nxt_q[30:0]};
	assign regen_word = tw_rd ^ (regen_y >> 1) ^ (regen_y[0] ? TW_MATA : 32'd0);

	always_comb begin
		tw_req = '0;
		case (state_q)
			S_SEED0: begin
				tw_req.we    = 1'b1;
				tw_req.waddr = 10'd0;
				tw_req.wdata = seed_q;
			end
			S_SADD: begin
				tw_req.we    = 1'b1;
				tw_req.waddr = idx_q;
				tw_req.wdata = seed_word;
			end
			S_ISSUE: tw_req.raddr = pos_q;
			S_RG0:   tw_req.raddr = 10'd0;
			S_RGL:   tw_req.raddr = 10'd1;
			S_RG1:   tw_req.raddr = idx_p1;
			S_RG2:   tw_req.raddr = idx_pm;
			S_RG3: begin
				tw_req.we    = 1'b1;
				tw_req.waddr = idx_q;
				tw_req.wdata = regen_word;
			end
			default: ;
		endcase
	end

	// draw evaluation
	logic [31:0] u;
	logic        c_last, p_last;
	assign u      = tw_temper(tw_rd);
	assign c_last = (NCW'(c_q) + NCW'(1) == nc_eff);
	assign p_last = (NPW'(p_q) + NPW'(1) == np_eff);

	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SEED0;
			phase_q     <= PH_NOISE;
			pos_q       <= N_W;
			idx_q       <= '0;
			p_q         <= '0;
			c_q         <= '0;
			bits_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load a finished sample, else drop a taken one
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && kind == K_RESTART) begin
						state_q <= S_SEED0;
					end else if (in_acc && kind == K_SAMPLE) begin
						bits_q <= '0;
						p_q    <= '0;
						c_q    <= '0;
						if (nc_eff != '0) begin
							phase_q <= PH_NOISE;
							state_q <= S_ISSUE;
						end else if (np_eff != '0) begin
							phase_q <= PH_PRIOR;
							state_q <= S_ISSUE;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SEED0: begin
					prev_q  <= seed_q;
					idx_q   <= 10'd1;
					state_q <= S_SMUL;
				end
				S_SMUL: begin
					mul_s1  <= 32'(TW_MULT * (prev_q ^ (prev_q >> 30)));
					state_q <= S_SADD;
				end
				S_SADD: begin
					prev_q <= seed_word;
					if (idx_q == N_W - 10'd1) begin
						pos_q   <= N_W;
						state_q <= S_IDLE;
					end else begin
						idx_q   <= idx_q + 10'd1;
						state_q <= S_SMUL;
					end
				end
				S_ISSUE: begin
					state_q <= (pos_q == N_W) ? S_RG0 : S_EVAL;
				end
				S_EVAL: begin
					case (phase_q)
						PH_NOISE: begin
							pos_q <= pos_q + 10'd1;
							if (u > noise_rd_q) bits_q[c_q] <= 1'b1;
							if (c_last) begin
								c_q     <= '0;
								phase_q <= PH_PRIOR;
								state_q <= (np_eff != '0) ? S_ISSUE : S_DONE;
							end else begin
								c_q     <= c_q + CIW'(1);
								state_q <= S_ISSUE;
							end
						end
						PH_PRIOR: begin
							pos_q <= pos_q + 10'd1;
							if (u < prior_rd_q && nc_eff != '0) begin
								phase_q <= PH_WEIGHT;
								c_q     <= '0;
								state_q <= S_ISSUE;
							end else if (p_last) begin
								state_q <= S_DONE;
							end else begin
								p_q     <= p_q + PIW'(1);
								state_q <= S_ISSUE;
							end
						end
						default: begin
							// a weight of exactly one takes no draw
							if (weight_rd_q != FULL_ONE) begin
								pos_q <= pos_q + 10'd1;
								if (u > weight_rd_q) bits_q[c_q] <= 1'b1;
							end
							if (c_last) begin
								c_q     <= '0;
								phase_q <= PH_PRIOR;
								if (p_last) begin
									state_q <= S_DONE;
								end else begin
									p_q     <= p_q + PIW'(1);
									state_q <= S_ISSUE;
								end
							end else begin
								c_q     <= c_q + CIW'(1);
								state_q <= S_ISSUE;
							end
						end
					endcase
				end
				S_RG0: begin
					idx_q   <= '0;
					state_q <= S_RGL;
				end
				S_RGL: begin
					cur_q   <= tw_rd;
					state_q <= S_RG2;
				end
				S_RG1: begin
					state_q <= S_RG2;
				end
				S_RG2: begin
					nxt_q   <= tw_rd;
					state_q <= S_RG3;
				end
				S_RG3: begin
					cur_q <= nxt_q;
					if (idx_q == N_W - 10'd1) begin
						pos_q   <= '0;
						state_q <= S_ISSUE;
					end else begin
						idx_q   <= idx_q + 10'd1;
						state_q <= S_RG1;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_bits_q  <= 64'(bits_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign obs_bits  = out_bits_q;

	// checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= N_W) else $error("generator position out of range");

	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> out_valid)
		else $error("finished sample not presented");

	a_draw_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> (pos_q != N_W))
		else $error("draw taken from an exhausted word memory");

	a_regen_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RG3 && idx_q == N_W - 10'd1) |=> (pos_q == 10'd0))
		else $error("position not cleared after regeneration");

endmodule

### bench/nons_sample_checker.sv
module nons_sample_checker
	import nons_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  kind,
	input  logic [5:0]  parent_index,
	input  logic [5:0]  child_index,
	input  logic [31:0] probability,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] obs_bits,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fails,
	output int          outstanding
);

	// shadow of the block's registers and tables
	logic [6:0]  npar_r;
	logic [6:0]  nchi_r;
	logic [31:0] seed_r;
	logic [31:0] tw[TW_N];
	int          tw_pos;
	logic [31:0] prior_m[64];
	logic [31:0] noise_m[64];
	logic [31:0] weight_m[4096];
	logic [63:0] exp_obs[$];

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("checker: %s, want %h got %h", what, want, got);
		fails++;
	endtask

	// seed the twister words from one 32-bit value
	task automatic reseed(input logic [31:0] s);
		tw[0] = s;
		for (int i = 1; i < TW_N; i++)
			tw[i] = TW_MULT * (tw[i-1] ^ (tw[i-1] >> 30)) + i;
		tw_pos = TW_N;
	endtask

	// one tempered generator output, regenerating the words when used up
	function automatic logic [31:0] next_draw();
		logic [31:0] y;
		logic [31:0] v;
		if (tw_pos >= TW_N) begin
			for (int i = 0; i < TW_N; i++) begin
				y = (tw[i] & 32'h80000000) | (tw[(i + 1) % TW_N] & 32'h7FFFFFFF);
				v = tw[(i + TW_M) % TW_N] ^ (y >> 1);
				if (y[0])
					v = v ^ TW_MATA;
				tw[i] = v;
			end
			tw_pos = 0;
		end
		y = tw[tw_pos];
		tw_pos++;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & 32'h9D2C5680);
		y = y ^ ((y << 15) & 32'hEFC60000);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// noise layer first, then each active parent flips children on
	function automatic logic [63:0] predict_obs();
		int          np;
		int          nc;
		logic [63:0] b;
		logic [31:0] w;
		np = (npar_r > 64) ? 64 : npar_r;
		nc = (nchi_r > 64) ? 64 : nchi_r;
		b = '0;
		for (int c = 0; c < nc; c++)
			if (next_draw() > noise_m[c])
				b[c] = 1'b1;
		for (int p = 0; p < np; p++) begin
			if (next_draw() < prior_m[p]) begin
				for (int c = 0; c < nc; c++) begin
					w = weight_m[p * 64 + c];
					if (w != FULL_ONE && next_draw() > w)
						b[c] = 1'b1;
				end
			end
		end
		return b;
	endfunction

	initial begin
		fails = 0;
		outstanding = 0;
		npar_r = 7'd1;
		nchi_r = 7'd1;
		seed_r = '0;
		reseed(32'd0);
	end

	always @(posedge clk) begin
		logic [63:0] want;
		if (arst_n) begin
			// results
			if (out_valid && !out_stall) begin
				if (exp_obs.size() == 0) begin
					report("result with no sample pending", '0, obs_bits);
				end else begin
					want = exp_obs.pop_front();
					if (obs_bits !== want)
						report("obs_bits mismatch", want, obs_bits);
				end
			end
			// register writes
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					R_NPAR: npar_r = pwdata[6:0];
					R_NCHI: nchi_r = pwdata[6:0];
					R_SEED: seed_r = pwdata;
					default: ;
				endcase
			end
			// requests
			if (in_valid && !in_stall) begin
				case (kind)
					K_PRIOR:   prior_m[parent_index] = probability;
					K_NOISE:   noise_m[child_index] = probability;
					K_WEIGHT:  weight_m[parent_index * 64 + child_index] = probability;
					K_RESTART: reseed(seed_r);
					K_SAMPLE:  exp_obs.push_back(predict_obs());
					default: ;
				endcase
			end
			outstanding <= exp_obs.size();
		end
	end

endmodule

### bench/tb.sv
module tb;
	import nons_pkg::*;

	localparam int LIMIT = 3000000;
	localparam int HOLD  = 4000;
	localparam int HOT   = 4;	// only these parents ever get a nonzero prior

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [5:0]  parent_index;
	logic [5:0]  child_index;
	logic [31:0] probability;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] obs_bits;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fails;
	int outstanding;
	int cycles;
	int send_idle;
	int recv_idle;
	int hold_req;
	int hold_ack;
	int hold_left;

	// which table entries hold a value, so a sample never reads a blank one
	bit          pr_ok[64];
	bit          nz_ok[64];
	bit          wt_ok[64][64];
	logic [31:0] pr_val[64];
	int          eff_np;
	int          eff_nc;

	noisy_or_network_sampler DUT (.*);

	nons_sample_checker chk (.*);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = K_PRIOR;
		parent_index = '0;
		child_index = '0;
		probability = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		send_idle = 0;
		recv_idle = 0;
		hold_req = 0;
		hold_ack = 0;
		hold_left = 0;
		eff_np = 1;
		eff_nc = 1;
	end

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
		int v;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		v = val[6:0];
		if (v > 64)
			v = 64;
		if (idx == R_NPAR)
			eff_np = v;
		else if (idx == R_NCHI)
			eff_nc = v;
	endtask

	// one request, with random idle cycles ahead of it
	task automatic send(input logic [2:0] k, input logic [5:0] p, input logic [5:0] c,
			input logic [31:0] prob);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		parent_index <= p;
		child_index <= c;
		probability <= prob;
		do
			@(posedge clk);
		while (in_stall);
		case (k)
			K_PRIOR: begin
				pr_ok[p] = 1'b1;
				pr_val[p] = prob;
			end
			K_NOISE:  nz_ok[c] = 1'b1;
			K_WEIGHT: wt_ok[p][c] = 1'b1;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_prob();
		case ($urandom_range(5))
			0: return 32'd0;
			1: return FULL_ONE;
			2: return FULL_ONE - 1;
			3: return $urandom;
			4: return $urandom_range(32'h3FFFFFFF);
			default: return 32'hC0000000 | $urandom;
		endcase
	endfunction

	function automatic logic [5:0] rnd6();
		return 6'($urandom_range(63));
	endfunction

	// fill every entry the next sample reads, then ask for the sample
	task automatic take_sample();
		for (int c = 0; c < eff_nc; c++)
			if (!nz_ok[c])
				send(K_NOISE, rnd6(), 6'(c), pick_prob());
		for (int p = 0; p < eff_np; p++)
			if (!pr_ok[p])
				send(K_PRIOR, 6'(p), rnd6(), (p < HOT) ? pick_prob() : 32'd0);
		for (int p = 0; p < eff_np; p++)
			if (pr_val[p] != 0)
				for (int c = 0; c < eff_nc; c++)
					if (!wt_ok[p][c])
						send(K_WEIGHT, 6'(p), 6'(c), pick_prob());
		send(K_SAMPLE, rnd6(), rnd6(), $urandom);
	endtask

	task automatic random_item();
		int          r;
		logic [5:0]  p;
		r = $urandom_range(99);
		p = rnd6();
		if (r < 35)
			take_sample();
		else if (r < 50)
			send(K_PRIOR, p, rnd6(), (p < HOT) ? pick_prob() : 32'd0);
		else if (r < 65)
			send(K_NOISE, rnd6(), rnd6(), pick_prob());
		else if (r < 85)
			send(K_WEIGHT, p, rnd6(), pick_prob());
		else if (r < 92)
			send(K_RESTART, rnd6(), rnd6(), $urandom);
		else
			send(3'(5 + $urandom_range(2)), rnd6(), rnd6(), $urandom);
	endtask

	// all results in, then room for a restart still running
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (2500) @(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// let the seeding after reset finish
		quiesce();
		cfg_write(R_NPAR, 32'd1);
		cfg_write(R_NCHI, 32'd1);
		cfg_write(R_SEED, 32'hFFFFFFFF);

		// directed: corner probabilities on a one-by-one network
		send(K_RESTART, 6'd0, 6'd0, 32'd0);
		send(K_PRIOR, 6'd0, 6'd0, FULL_ONE);
		send(K_NOISE, 6'd0, 6'd0, 32'd0);
		send(K_WEIGHT, 6'd0, 6'd0, 32'd0);
		send(K_SAMPLE, 6'd0, 6'd0, 32'd0);
		send(K_WEIGHT, 6'd0, 6'd0, FULL_ONE);
		send(K_SAMPLE, 6'd63, 6'd63, FULL_ONE);
		send(K_NOISE, 6'd0, 6'd0, FULL_ONE);
		send(K_SAMPLE, 6'd0, 6'd0, 32'd0);
		send(K_PRIOR, 6'd0, 6'd0, 32'd0);
		send(K_SAMPLE, 6'd0, 6'd0, 32'd0);
		send(K_PRIOR, 6'd63, 6'd0, 32'd0);
		send(K_NOISE, 6'd0, 6'd63, FULL_ONE);
		send(K_WEIGHT, 6'd63, 6'd63, 32'h80000000);
		send(3'd5, 6'd63, 6'd63, FULL_ONE);
		send(3'd6, 6'd0, 6'd0, 32'd0);
		send(3'd7, 6'd21, 6'd42, 32'h5A5A5A5A);
		send(K_RESTART, 6'd0, 6'd0, 32'd0);
		send(K_SAMPLE, 6'd0, 6'd0, 32'd0);

		// empty network: no parents, no children
		quiesce();
		cfg_write(R_NPAR, 32'd0);
		cfg_write(R_NCHI, 32'd0);
		send(K_SAMPLE, 6'd0, 6'd0, 32'd0);
		send(K_SAMPLE, 6'd0, 6'd0, 32'd0);

		// child count above the table size saturates at the maximum
		quiesce();
		cfg_write(R_NPAR, 32'd0);
		cfg_write(R_NCHI, 32'd127);
		cfg_write(R_SEED, 32'd0);
		send(K_RESTART, 6'd0, 6'd0, 32'd0);
		take_sample();
		take_sample();

		// random phases with changing idle patterns
		for (int ph = 0; ph < 3; ph++) begin
			quiesce();
			send_idle = (ph == 0) ? 20 : (ph == 1) ? 69 : 0;
			recv_idle <= (ph == 0) ? 69 : (ph == 1) ? 20 : 0;
			cfg_write(R_NPAR, 32'($urandom_range(1, 4)));
			cfg_write(R_NCHI, 32'($urandom_range(1, 8)));
			cfg_write(R_SEED, $urandom);
			send(K_RESTART, rnd6(), rnd6(), $urandom);
			for (int n = 0; n < 6; n++) begin
				random_item();
				if (ph == 0 && n == 2) begin
					// sender waits for every result
					in_valid <= 1'b0;
					@(posedge clk);
					while (outstanding != 0)
						@(posedge clk);
				end
				if (ph == 2 && n == 1) begin
					// long receiver hold-off while samples keep coming
					hold_req <= hold_req + 1;
					for (int s = 0; s < 6; s++)
						take_sample();
				end
			end
		end

		// drain
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3000) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

### files.f
design/nons_pkg.sv
design/nons_tw_ram.sv
design/noisy_or_network_sampler.sv
bench/nons_sample_checker.sv
bench/tb.sv
